>>> design/sin_cos_two_pi_approx_macros.svh
// assertion macros used by the top-level design file
`ifndef SIN_COS_TWO_PI_APPROX_MACROS_SVH
`define SIN_COS_TWO_PI_APPROX_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define SCTP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sctp assertion failed");

// next-cycle implication, checked on clk, off during reset
`define SCTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sctp assertion failed");

`endif

>>> design/sctp_pkg.sv
package sctp_pkg;

  // fraction bits of x and of every chebyshev term
  localparam int WF = 30;
  localparam int ZW = 32;

  // coefficient products and their sum
  localparam int CW   = 34;
  localparam int PW   = CW + ZW;
  localparam int SUMW = PW + 2;

  typedef logic signed [ZW-1:0] fix_t;
  typedef logic signed [CW-1:0] coef_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic [2:0] term_idx_t;

  localparam fix_t Z_ONE = fix_t'(1) <<< WF;

  // round(c * 2^32)
  localparam coef_t COEF1 = 34'sd4868981849;
  localparam coef_t COEF3 = -34'sd593013765;
  localparam coef_t COEF5 = 34'sd19287485;
  localparam coef_t COEF7 = -34'sd293305;

  localparam term_idx_t IDX_T1 = 3'd1;
  localparam term_idx_t IDX_T3 = 3'd3;
  localparam term_idx_t IDX_T5 = 3'd5;

  // recurrence state carried down the pipeline
  typedef struct packed {
    term_idx_t idx;
    fix_t      x;
    fix_t      z_prev;
    fix_t      z_cur;
    fix_t      z3;
    fix_t      z5;
  } cheb_t;

endpackage

>>> design/sctp_fold.sv
module sctp_fold #(
  parameter int PHASE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [PHASE_BITS-1:0] in_phase,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sctp_pkg::cheb_t       out_data
);
  import sctp_pkg::*;

  localparam int YW = PHASE_BITS + 2;
  localparam int EW = PHASE_BITS + 34;
  localparam int SHR = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
  localparam int SHL = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
  localparam int RND_POS = (SHR > 0) ? SHR - 1 : 0;

  localparam logic [YW-1:0] Q1 = YW'(1) << (PHASE_BITS - 2);
  localparam logic [YW-1:0] Q2 = Q1 << 1;
  localparam logic [YW-1:0] Q3 = Q1 + Q2;
  localparam logic [YW-1:0] Q4 = Q1 << 2;
  localparam logic signed [EW-1:0] RND = EW'(SHR > 0) << RND_POS;

  logic [YW-1:0]        a_x;
  logic signed [YW-1:0] y;
  logic signed [EW-1:0] y_ext;
  logic signed [EW-1:0] y_rnd;
  logic signed [EW-1:0] x_ext;
  logic                 valid_r;
  cheb_t                data_r;
  cheb_t                data_nxt;

  assign a_x = {2'b00, in_phase};

  always_comb begin
    if (!in_cmd) begin
      if (a_x >= Q3) begin
        y = $signed(a_x - Q4);
      end else if (a_x >= Q1) begin
        y = $signed(Q2 - a_x);
      end else begin
        y = $signed(a_x);
      end
    end else begin
      if (a_x >= Q2) begin
        y = $signed(a_x - Q3);
      end else begin
        y = $signed(Q1 - a_x);
      end
    end
  end

  // bring y to WF fraction bits, rounding half up on a right shift
  always_comb begin
    y_ext = {{(EW-YW){y[YW-1]}}, y};
    y_rnd = y_ext + RND;
    x_ext = (y_rnd >>> SHR) <<< SHL;
  end

  always_comb begin
    data_nxt.idx    = IDX_T1;
    data_nxt.x      = x_ext[ZW-1:0];
    data_nxt.z_prev = Z_ONE;
    data_nxt.z_cur  = x_ext[ZW-1:0];
    data_nxt.z3     = '0;
    data_nxt.z5     = '0;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> design/sctp_recur.sv
module sctp_recur (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sctp_pkg::cheb_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output sctp_pkg::cheb_t out_data
);
  import sctp_pkg::*;

  localparam logic signed [2*ZW-1:0] HALF = (2*ZW)'(1) <<< (WF - 2);

  logic signed [2*ZW-1:0] prod;
  logic signed [2*ZW-1:0] prod_sh;
  fix_t                   z_new;
  term_idx_t              idx_new;
  logic                   valid_r;
  cheb_t                  data_r;
  cheb_t                  data_nxt;

  // T(k+1) = round(2 x T(k)) - T(k-1), doubled product rounded to WF fraction bits
  always_comb begin
    prod    = in_data.x * in_data.z_cur;
    prod_sh = (prod + HALF) >>> (WF - 1);
    z_new   = prod_sh[ZW-1:0] - in_data.z_prev;
    idx_new = in_data.idx + term_idx_t'(1);
  end

  always_comb begin
    data_nxt        = in_data;
    data_nxt.idx    = idx_new;
    data_nxt.z_prev = in_data.z_cur;
    data_nxt.z_cur  = z_new;
    if (idx_new == IDX_T3) begin
      data_nxt.z3 = z_new;
    end
    if (idx_new == IDX_T5) begin
      data_nxt.z5 = z_new;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> design/sctp_sum.sv
module sctp_sum #(
  parameter int RESULT_FRAC_BITS = 30
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sctp_pkg::cheb_t                    in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [RESULT_FRAC_BITS+1:0] out_value
);
  import sctp_pkg::*;

  localparam int VW = RESULT_FRAC_BITS + 2;
  localparam int SH = 2 * WF + 2 - RESULT_FRAC_BITS;
  localparam logic signed [SUMW-1:0] HALF    = SUMW'(1) <<< (SH - 1);
  localparam logic signed [SUMW-1:0] ONE     = SUMW'(1) <<< RESULT_FRAC_BITS;
  localparam logic signed [SUMW-1:0] NEG_ONE = -ONE;

  // product stage
  prod_t p1_r, p3_r, p5_r, p7_r;
  prod_t p1_nxt, p3_nxt, p5_nxt, p7_nxt;
  logic  pv_r;
  logic  p_ready;

  // sum and clip stage
  logic signed [SUMW-1:0] sum;
  logic signed [SUMW-1:0] sum_sh;
  logic signed [SUMW-1:0] clip;
  logic signed [VW-1:0]   value_r;
  logic                   ov_r;

  always_comb begin
    p1_nxt = COEF1 * in_data.x;
    p3_nxt = COEF3 * in_data.z3;
    p5_nxt = COEF5 * in_data.z5;
    p7_nxt = COEF7 * in_data.z_cur;
  end

  assign in_ready = !pv_r || p_ready;
  assign p_ready  = !ov_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (in_ready) begin
        pv_r <= in_valid;
      end
      if (p_ready) begin
        ov_r <= pv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      p1_r <= p1_nxt;
      p3_r <= p3_nxt;
      p5_r <= p5_nxt;
      p7_r <= p7_nxt;
    end
  end

  always_comb begin
    sum = {{2{p1_r[PW-1]}}, p1_r} + {{2{p3_r[PW-1]}}, p3_r}
        + {{2{p5_r[PW-1]}}, p5_r} + {{2{p7_r[PW-1]}}, p7_r};
    sum_sh = (sum + HALF) >>> SH;
    if (sum_sh > ONE) begin
      clip = ONE;
    end else if (sum_sh < NEG_ONE) begin
      clip = NEG_ONE;
    end else begin
      clip = sum_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (pv_r && p_ready) begin
      value_r <= clip[VW-1:0];
    end
  end

  assign out_valid = ov_r;
  assign out_value = value_r;

endmodule

>>> design/sin_cos_two_pi_approx.sv
// pipeline: fold, six recurrence steps, coefficient products, sum and clip,
// one register stage each
// throughput: one transaction per cycle; a stalled result holds only the stages that
// are full, so input stops only once all nine stages hold a transaction
// reset: synchronous active-low rst_n clears all stage valid bits; no other state
module sin_cos_two_pi_approx #(
  parameter int PHASE_BITS       = 32,
  parameter int RESULT_FRAC_BITS = 30
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic [PHASE_BITS-1:0]              in_phase,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [RESULT_FRAC_BITS+1:0] out_value
);
  import sctp_pkg::*;

  `include "sin_cos_two_pi_approx_macros.svh"

  localparam int STEPS = 6;
  localparam int VW = RESULT_FRAC_BITS + 2;
  localparam logic signed [VW-1:0] VAL_ONE = VW'(1) <<< RESULT_FRAC_BITS;
  localparam fix_t NEG_Z_ONE = -Z_ONE;

  cheb_t stg_data  [0:STEPS];
  logic  stg_valid [0:STEPS];
  logic  stg_ready [0:STEPS];

  sctp_fold #(
    .PHASE_BITS(PHASE_BITS)
  ) u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .in_phase (in_phase),
    .out_valid(stg_valid[0]),
    .out_ready(stg_ready[0]),
    .out_data (stg_data[0])
  );

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    sctp_recur u_recur (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (stg_valid[g]),
      .in_ready (stg_ready[g]),
      .in_data  (stg_data[g]),
      .out_valid(stg_valid[g+1]),
      .out_ready(stg_ready[g+1]),
      .out_data (stg_data[g+1])
    );
  end

  sctp_sum #(
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
  ) u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (stg_valid[STEPS]),
    .in_ready (stg_ready[STEPS]),
    .in_data  (stg_data[STEPS]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_value(out_value)
  );

  // an accepted transaction always lands in the fold register
  `SCTP_ASSERT_NEXT(a_fold_load, in_valid && in_ready, stg_valid[0])

  // folded argument stays within plus or minus one
  `SCTP_ASSERT_SAME(a_x_range, stg_valid[0], (stg_data[0].x <= Z_ONE) && (stg_data[0].x >= NEG_Z_ONE))

  // result is clipped to plus or minus one
  `SCTP_ASSERT_SAME(a_out_range, out_valid, (out_value <= VAL_ONE) && (out_value >= -VAL_ONE))

endmodule

>>> verif/sin_cos_two_pi_approx_tb.sv
`timescale 1ns / 1ps

module sin_cos_two_pi_approx_tb;
  import sctp_pkg::*;

  localparam int PHASE_BITS = 32;
  localparam int RESULT_FRAC_BITS = 30;
  localparam int RANDOM_ITEMS = 1800;
  localparam int DRAIN_CYCLES = 12;

  localparam logic CMD_SIN = 1'b0;
  localparam logic CMD_COS = 1'b1;

  typedef logic [PHASE_BITS-1:0] phase_t;

  typedef struct packed {
    logic   cmd;
    phase_t phase;
    logic   known;
    fix_t   value;
  } dir_row_t;

  // zero crossings are exact; everything else goes through the predictor
  localparam int NUM_DIR = 23;
  localparam dir_row_t DIR_ROWS [0:NUM_DIR-1] = '{
    '{CMD_SIN, 32'h0000_0000, 1'b1, 32'sd0},
    '{CMD_SIN, 32'h0000_0001, 1'b0, 32'sd0},
    '{CMD_SIN, 32'h3FFF_FFFF, 1'b0, 32'sd0},
    '{CMD_SIN, 32'h4000_0000, 1'b0, 32'sd0},
    '{CMD_SIN, 32'h4000_0001, 1'b0, 32'sd0},
    '{CMD_SIN, 32'h7FFF_FFFF, 1'b0, 32'sd0},
    '{CMD_SIN, 32'h8000_0000, 1'b1, 32'sd0},
    '{CMD_SIN, 32'hBFFF_FFFF, 1'b0, 32'sd0},
    '{CMD_SIN, 32'hC000_0000, 1'b0, 32'sd0},
    '{CMD_SIN, 32'hFFFF_FFFF, 1'b0, 32'sd0},
    '{CMD_SIN, 32'h3F00_0000, 1'b0, 32'sd0},
    '{CMD_SIN, 32'h4100_0000, 1'b0, 32'sd0},
    '{CMD_SIN, 32'h0AAA_AAAA, 1'b0, 32'sd0},
    '{CMD_COS, 32'h0000_0000, 1'b0, 32'sd0},
    '{CMD_COS, 32'h0000_0001, 1'b0, 32'sd0},
    '{CMD_COS, 32'h4000_0000, 1'b1, 32'sd0},
    '{CMD_COS, 32'h7FFF_FFFF, 1'b0, 32'sd0},
    '{CMD_COS, 32'h8000_0000, 1'b0, 32'sd0},
    '{CMD_COS, 32'hBFFF_FFFF, 1'b0, 32'sd0},
    '{CMD_COS, 32'hC000_0000, 1'b1, 32'sd0},
    '{CMD_COS, 32'hFFFF_FFFF, 1'b0, 32'sd0},
    '{CMD_COS, 32'h2000_0000, 1'b0, 32'sd0},
    '{CMD_COS, 32'h5555_5555, 1'b0, 32'sd0}
  };

  logic   clk;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  logic   in_cmd = CMD_SIN;
  phase_t in_phase = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  fix_t   out_value;

  fix_t pending_values[$];
  bit   calm = 1'b0;
  int   fail_count = 0;
  int   checked_count = 0;
  int   sin_count = 0;
  int   cos_count = 0;

  sin_cos_two_pi_approx #(
    .PHASE_BITS      (PHASE_BITS),
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .in_phase (in_phase),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_value(out_value)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // round half up, then arithmetic shift
  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic fix_t sincos_fixed(input logic cmd, input phase_t phase);
    longint quarter, a, y, x, acc, r, one;
    longint z [0:7];
    quarter = 64'sd1 <<< (PHASE_BITS - 2);
    a = longint'({32'b0, phase});
    // fold to within a quarter turn of zero
    if (cmd == CMD_SIN) begin
      if (a >= 3 * quarter) y = a - 4 * quarter;
      else if (a >= quarter) y = 2 * quarter - a;
      else y = a;
    end else begin
      if (a >= 2 * quarter) y = a - 3 * quarter;
      else y = quarter - a;
    end
    if (PHASE_BITS - 2 > WF) x = round_shift(y, PHASE_BITS - 2 - WF);
    else x = y <<< (WF - (PHASE_BITS - 2));
    z[0] = 64'sd1 <<< WF;
    z[1] = x;
    for (int k = 1; k < 7; k++) begin
      z[k + 1] = round_shift(x * z[k], WF - 1) - z[k - 1];
    end
    acc = longint'(COEF1) * z[1] + longint'(COEF3) * z[3]
        + longint'(COEF5) * z[5] + longint'(COEF7) * z[7];
    r = round_shift(acc, 2 * WF + 2 - RESULT_FRAC_BITS);
    one = 64'sd1 <<< RESULT_FRAC_BITS;
    if (r > one) r = one;
    if (r < -one) r = -one;
    return fix_t'(r);
  endfunction

  task automatic send_phase(input logic cmd, input phase_t phase, input logic known,
                            input fix_t value);
    if (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_phase <= phase;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_values.push_back(known ? value : sincos_fixed(cmd, phase));
    if (cmd == CMD_SIN) sin_count++;
    else cos_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_values.size() != 0) @(posedge clk);
  endtask

  function automatic phase_t pick_phase(input logic cmd);
    phase_t peak;
    case ($urandom_range(3))
      0, 1: return phase_t'($urandom());
      // around the fold points
      2: return phase_t'($urandom_range(3)) * 32'h4000_0000
                + phase_t'($urandom_range(64)) - 32'd32;
      default: begin
        // around the crests, where overshoot would show
        peak = (cmd == CMD_SIN) ? 32'h4000_0000 : 32'h0000_0000;
        if ($urandom_range(1)) peak = peak + 32'h8000_0000;
        return peak + phase_t'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
      end
    endcase
  endfunction

  // result side: random back-pressure and in-order compare
  always @(posedge clk) begin : result_check
    fix_t want;
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 30);
    if (rst_n && out_valid && out_ready) begin
      if (pending_values.size() == 0) begin
        $error("unexpected result transaction: value %0d", out_value);
        fail_count++;
      end else begin
        want = pending_values.pop_front();
        checked_count++;
        if (out_value !== want) begin
          $error("value: expected %0d, got %0d", want, out_value);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic cmd;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIR; i++) begin
      send_phase(DIR_ROWS[i].cmd, DIR_ROWS[i].phase, DIR_ROWS[i].known, DIR_ROWS[i].value);
    end
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 600 && i < 900);
      if (i == 1200) wait_drained();
      cmd = logic'($urandom_range(1));
      send_phase(cmd, pick_phase(cmd), 1'b0, '0);
    end
    calm = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d sine and %0d cosine transactions, %0d results compared",
             sin_count, cos_count, checked_count);
    $display("tb: folds, crests, phase extremes, full stalls and a no-idle stretch exercised");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/sctp_pkg.sv
design/sctp_fold.sv
design/sctp_recur.sv
design/sctp_sum.sv
design/sin_cos_two_pi_approx.sv
verif/sin_cos_two_pi_approx_tb.sv
